FILE: hw/rtl/klpd_pkg.sv
// Package for the key long-press detector: payload structs, codes and sizes.
// Used by klpd_core, klpd_out and key_long_press_detector_top; no dependencies.
package klpd_pkg;

    localparam int HOLD_SLOTS = 4;
    localparam int KEY_W      = 16;
    localparam int TICKS_W    = 16;
    localparam int PCOUNT_W   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Most results one input can cause: one per slot on a tick, two on a release.
    localparam int MAX_RES = (HOLD_SLOTS > 2) ? HOLD_SLOTS : 2;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [1:0] OP_KEY     = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_ALL_UP  = 2'd2;
    localparam logic [1:0] OP_UNSTUCK = 2'd3;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_HOLD    = 2'd2;
    localparam logic [1:0] KIND_UNSTUCK = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key_code;
        logic             is_press;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [KEY_W-1:0] event_key;
        logic             any_key_down;
        logic [KEY_W-1:0] recent_key;
        logic             recent_press;
        logic             run_end;
    } t_out_item;

    // One result before the per-request fields are attached.
    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic             down;
    } t_res;

    // All results of one request, handed from the core to the output stage.
    typedef struct packed {
        logic                    load;
        logic [CNT_W-1:0]        cnt;
        t_res [MAX_RES-1:0]      res;
        logic [KEY_W-1:0]        recent_key;
        logic                    recent_press;
    } t_batch;

endpackage

FILE: hw/rtl/klpd_core.sv
// Input register, configuration registers, hold-slot state and event logic.
// Depends on klpd_pkg; feeds a result batch to klpd_out.
module klpd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  klpd_pkg::t_in_item            i_in_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [klpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [klpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_batch_free,
    output klpd_pkg::t_batch              o_batch
);
    import klpd_pkg::*;

    logic                r_in_vld;
    t_in_item            r_in;

    logic [KEY_W-1:0]    r_slot_key   [HOLD_SLOTS];
    logic [TICKS_W-1:0]  r_slot_ticks [HOLD_SLOTS];

    logic [HOLD_SLOTS-1:0] r_down,  n_down;
    logic [HOLD_SLOTS-1:0] r_fired, n_fired;
    logic [TICKS_W-1:0]  r_rem [HOLD_SLOTS];
    logic [TICKS_W-1:0]  n_rem [HOLD_SLOTS];
    logic [PCOUNT_W-1:0] r_pcount, n_pcount;
    logic [KEY_W-1:0]    r_latest_key, n_latest_key;
    logic                r_latest_press, n_latest_press;

    logic [HOLD_SLOTS-1:0] match;
    logic                  hit;
    logic [CNT_W-1:0]      n_cnt;
    t_res [MAX_RES-1:0]    n_res;
    t_res                  push_item;
    logic [TICKS_W-1:0]    dec_rem;
    logic                  accept;
    logic                  move;

    assign o_cfg_ready = 1'b1;

    // Lowest-numbered slot watching the key wins; key zero matches nothing.
    always_comb begin
        logic seen;
        seen  = 1'b0;
        match = '0;
        for (int s = 0; s < HOLD_SLOTS; s++) begin
            if (!seen && r_slot_key[s] == r_in.key_code && r_in.key_code != '0) begin
                match[s] = 1'b1;
                seen     = 1'b1;
            end
        end
        hit = seen;
    end

    always_comb begin
        n_down         = r_down;
        n_fired        = r_fired;
        n_rem          = r_rem;
        n_pcount       = r_pcount;
        n_latest_key   = r_latest_key;
        n_latest_press = r_latest_press;
        n_cnt          = '0;
        n_res          = '0;
        push_item      = '0;
        dec_rem        = '0;

        case (r_in.op)
            OP_KEY: begin
                if (!(r_in.key_code == '0 && !r_in.is_press)) begin
                    if (r_in.is_press) begin
                        if (r_pcount != {PCOUNT_W{1'b1}}) begin
                            n_pcount = r_pcount + PCOUNT_W'(1);
                        end
                        for (int s = 0; s < HOLD_SLOTS; s++) begin
                            if (match[s]) begin
                                n_down[s]  = 1'b1;
                                n_fired[s] = 1'b0;
                                n_rem[s]   = r_slot_ticks[s];
                            end
                        end
                        if (!hit) begin
                            push_item = '{kind: KIND_PRESS, key: r_in.key_code,
                                          down: (n_pcount != '0)};
                            for (int j = 0; j < MAX_RES; j++) begin
                                if (n_cnt == CNT_W'(j)) begin
                                    n_res[j] = push_item;
                                end
                            end
                            n_cnt = n_cnt + CNT_W'(1);
                        end
                    end else begin
                        if (r_pcount != '0) begin
                            n_pcount = r_pcount - PCOUNT_W'(1);
                        end
                        for (int s = 0; s < HOLD_SLOTS; s++) begin
                            if (match[s]) begin
                                // A press held back for a hold that never fired goes out first.
                                if (r_down[s] && !r_fired[s]) begin
                                    push_item = '{kind: KIND_PRESS, key: r_in.key_code,
                                                  down: 1'b1};
                                    for (int j = 0; j < MAX_RES; j++) begin
                                        if (n_cnt == CNT_W'(j)) begin
                                            n_res[j] = push_item;
                                        end
                                    end
                                    n_cnt = n_cnt + CNT_W'(1);
                                end
                                n_down[s] = 1'b0;
                            end
                        end
                        push_item = '{kind: KIND_RELEASE, key: r_in.key_code,
                                      down: (n_pcount != '0)};
                        for (int j = 0; j < MAX_RES; j++) begin
                            if (n_cnt == CNT_W'(j)) begin
                                n_res[j] = push_item;
                            end
                        end
                        n_cnt = n_cnt + CNT_W'(1);
                    end
                end
                n_latest_key   = r_in.key_code;
                n_latest_press = r_in.is_press;
            end
            OP_TICK: begin
                for (int s = 0; s < HOLD_SLOTS; s++) begin
                    if (r_slot_key[s] != '0 && r_down[s] && !r_fired[s]) begin
                        dec_rem  = (r_rem[s] != '0) ? r_rem[s] - TICKS_W'(1) : '0;
                        n_rem[s] = dec_rem;
                        if (dec_rem == '0) begin
                            n_fired[s] = 1'b1;
                            push_item  = '{kind: KIND_HOLD, key: r_slot_key[s],
                                           down: (r_pcount != '0)};
                            for (int j = 0; j < MAX_RES; j++) begin
                                if (n_cnt == CNT_W'(j)) begin
                                    n_res[j] = push_item;
                                end
                            end
                            n_cnt = n_cnt + CNT_W'(1);
                        end
                    end
                end
            end
            OP_ALL_UP: begin
                n_pcount = '0;
            end
            OP_UNSTUCK: begin
                n_pcount  = '0;
                push_item = '{kind: KIND_UNSTUCK, key: '0, down: 1'b0};
                n_res[0]  = push_item;
                n_cnt     = CNT_W'(1);
            end
            default: begin
                n_pcount = r_pcount;
            end
        endcase
    end

    // A request with no results never waits on the output stage.
    assign move       = r_in_vld && (n_cnt == '0 || i_batch_free);
    assign o_in_stall = r_in_vld && !move;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_batch.load         = move && (n_cnt != '0);
        o_batch.cnt          = n_cnt;
        o_batch.res          = n_res;
        o_batch.recent_key   = n_latest_key;
        o_batch.recent_press = n_latest_press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_down         <= '0;
            r_fired        <= '0;
            r_pcount       <= '0;
            r_latest_key   <= '0;
            r_latest_press <= 1'b0;
            for (int s = 0; s < HOLD_SLOTS; s++) begin
                r_rem[s]        <= '0;
                r_slot_key[s]   <= '0;
                r_slot_ticks[s] <= '0;
            end
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
                r_in     <= i_in_data;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_down         <= n_down;
                r_fired        <= n_fired;
                r_rem          <= n_rem;
                r_pcount       <= n_pcount;
                r_latest_key   <= n_latest_key;
                r_latest_press <= n_latest_press;
            end
            if (i_cfg_valid) begin
                for (int s = 0; s < HOLD_SLOTS; s++) begin
                    if (i_cfg_index == CFG_IDX_W'(2 * s)) begin
                        r_slot_key[s] <= i_cfg_data;
                    end
                    if (i_cfg_index == CFG_IDX_W'(2 * s + 1)) begin
                        r_slot_ticks[s] <= i_cfg_data;
                    end
                end
            end
        end
    end

endmodule

FILE: hw/rtl/klpd_out.sv
// Result register: holds one request's results and hands them out one per cycle unless stalled.
// Depends on klpd_pkg; loaded by klpd_core.
module klpd_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  klpd_pkg::t_batch     i_batch,
    output logic                 o_batch_free,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output klpd_pkg::t_out_item  o_out_data
);
    import klpd_pkg::*;

    logic               r_vld;
    logic [CNT_W-1:0]   r_left;
    t_res [MAX_RES-1:0] r_res;
    logic [KEY_W-1:0]   r_recent_key;
    logic               r_recent_press;
    logic               take;
    logic               last;

    assign last         = (r_left == CNT_W'(1));
    assign take         = r_vld && !i_out_stall;
    assign o_batch_free = !r_vld || (take && last);

    assign o_out_valid             = r_vld;
    assign o_out_data.event_kind   = r_res[0].kind;
    assign o_out_data.event_key    = r_res[0].key;
    assign o_out_data.any_key_down = r_res[0].down;
    assign o_out_data.recent_key   = r_recent_key;
    assign o_out_data.recent_press = r_recent_press;
    assign o_out_data.run_end      = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_left <= '0;
        end else begin
            if (i_batch.load) begin
                r_vld          <= 1'b1;
                r_left         <= i_batch.cnt;
                r_res          <= i_batch.res;
                r_recent_key   <= i_batch.recent_key;
                r_recent_press <= i_batch.recent_press;
            end else if (take) begin
                r_left <= r_left - CNT_W'(1);
                if (last) begin
                    r_vld <= 1'b0;
                end
                for (int j = 0; j < MAX_RES - 1; j++) begin
                    r_res[j] <= r_res[j + 1];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/key_long_press_detector_top.sv
// Key long-press detector. A request passes the klpd_core input register, then the
// klpd_out result register, and waits while that one is busy. Throughput: one
// request per cycle while the output is not stalled and each request has at most one
// result; n results hold the result register until all have left (up to four on a
// tick), one with none skips it. Synchronous active-low reset clears the hold slots,
// the pressed count, the latest event and the slot registers to zero. Depends on klpd_pkg, klpd_core and klpd_out.
module key_long_press_detector_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  klpd_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output klpd_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [klpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [klpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import klpd_pkg::*;

    t_batch batch;
    logic   batch_free;

    klpd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_batch_free (batch_free),
        .o_batch      (batch)
    );

    klpd_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_batch      (batch),
        .o_batch_free (batch_free),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    // A request's results leave without gaps until the last one.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.run_end) |=> o_out_valid)
        else $error("result run broken before its last result");

    a_unstuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_kind == KIND_UNSTUCK) |->
        (o_out_data.event_key == '0 && !o_out_data.any_key_down && o_out_data.run_end))
        else $error("unstuck result with wrong fields");

    a_press_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_kind == KIND_PRESS) |-> o_out_data.any_key_down)
        else $error("press result reports no key down");

    a_hold_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_kind == KIND_HOLD) |-> (o_out_data.event_key != '0))
        else $error("hold result for an unused slot");

endmodule
